FILE: hw/rtl/approx_euclid_distance_shift_table_macros.svh
// Assertion macros for the approximate Euclidean distance block.
// Used by the port checker; needs a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef APPROX_EUCLID_DISTANCE_SHIFT_TABLE_MACROS_SVH
`define APPROX_EUCLID_DISTANCE_SHIFT_TABLE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define AEDST_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aedst check failed");

// Next-cycle implication, held off during reset.
`define AEDST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aedst check failed");

`endif

FILE: hw/rtl/aedst_pkg.sv
// Shared types and constants for the approximate Euclidean distance block.
// No dependencies; imported by every RTL module of the block.
package aedst_pkg;

    localparam int COORD_W     = 31;
    localparam int AXIS_W      = 31;
    localparam int REM_W       = AXIS_W + 1;
    localparam int DIST_W      = 32;
    localparam int RATIO_SHIFT = 4;
    localparam int DIV_STEPS   = RATIO_SHIFT + 1;
    localparam int RATIO_MAX   = 1 << RATIO_SHIFT;
    localparam int IDX_W       = $clog2(RATIO_MAX + 1);
    localparam int SHIFT_W     = 4;

    localparam logic [SHIFT_W-1:0] SHIFT_A [0:RATIO_MAX] =
        '{4'd12, 4'd9, 4'd7, 4'd6, 4'd5, 4'd5, 4'd4, 4'd4, 4'd4,
          4'd3, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2};
    localparam logic [SHIFT_W-1:0] SHIFT_B [0:RATIO_MAX] =
        '{4'd12, 4'd9, 4'd9, 4'd8, 4'd12, 4'd6, 4'd7, 4'd5, 4'd4,
          4'd5, 4'd4, 4'd4, 4'd9, 4'd5, 4'd4, 4'd3, 4'd3};

    // One edge in flight through the divider chain.
    typedef struct packed {
        logic [AXIS_W-1:0]    major;
        logic [REM_W-1:0]     rem;
        logic [DIV_STEPS-1:0] quo;
        logic                 minor_nz;
        logic                 ok;
        logic                 last;
    } t_work;

endpackage

FILE: hw/rtl/aedst_div_cell.sv
// One restoring-division cell: produces one ratio bit per beat.
// Depends on aedst_pkg for t_work.
module aedst_div_cell
    import aedst_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_work i_work,
    output logic  o_valid,
    input  logic  i_ready,
    output t_work o_work
);

    logic              r_valid;
    t_work             r_work;
    t_work             n_work;
    logic [REM_W:0]    diff;
    logic              ge;
    logic [REM_W-1:0]  rem_sel;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        diff    = {1'b0, i_work.rem} - {2'b00, i_work.major};
        ge      = !diff[REM_W];
        rem_sel = ge ? diff[REM_W-1:0] : i_work.rem;
        n_work  = i_work;
        // remainder stays below major, so its top bit is free for the doubling
        n_work.rem = {rem_sel[REM_W-2:0], 1'b0};
        n_work.quo = {i_work.quo[DIV_STEPS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

FILE: hw/rtl/aedst_prep.sv
// Front end: absolute axis differences, then ordering into major and minor.
// Depends on aedst_pkg; feeds the first divider cell.
module aedst_prep
    import aedst_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_from_east,
    input  logic [COORD_W-1:0] i_from_north,
    input  logic [COORD_W-1:0] i_to_east,
    input  logic [COORD_W-1:0] i_to_north,
    input  logic               i_source_valid,
    input  logic               i_edge_present,
    input  logic               i_last_edge,
    output logic               o_valid,
    input  logic               i_ready,
    output t_work              o_work
);

    logic              r_v1;
    logic [AXIS_W-1:0] r_abs_e;
    logic [AXIS_W-1:0] r_abs_n;
    logic              r_ok;
    logic              r_last;
    logic              r_v2;
    t_work             r_work;
    t_work             n_work;
    logic              rdy1;
    logic              rdy2;
    logic [COORD_W:0]  de1, de2, dn1, dn2;
    logic [AXIS_W-1:0] n_abs_e;
    logic [AXIS_W-1:0] n_abs_n;
    logic              swap;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    // Both orders in parallel so the absolute value is one subtract deep.
    always_comb begin
        de1 = {i_from_east[COORD_W-1], i_from_east} - {i_to_east[COORD_W-1], i_to_east};
        de2 = {i_to_east[COORD_W-1], i_to_east} - {i_from_east[COORD_W-1], i_from_east};
        dn1 = {i_from_north[COORD_W-1], i_from_north} - {i_to_north[COORD_W-1], i_to_north};
        dn2 = {i_to_north[COORD_W-1], i_to_north} - {i_from_north[COORD_W-1], i_from_north};
        n_abs_e = de1[COORD_W] ? de2[AXIS_W-1:0] : de1[AXIS_W-1:0];
        n_abs_n = dn1[COORD_W] ? dn2[AXIS_W-1:0] : dn1[AXIS_W-1:0];
    end

    always_comb begin
        swap            = r_abs_e < r_abs_n;
        n_work.major    = swap ? r_abs_n : r_abs_e;
        n_work.rem      = {1'b0, (swap ? r_abs_e : r_abs_n)};
        n_work.quo      = '0;
        n_work.minor_nz = (swap ? r_abs_e : r_abs_n) != '0;
        n_work.ok       = r_ok;
        n_work.last     = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_abs_e <= n_abs_e;
            r_abs_n <= n_abs_n;
            r_ok    <= i_source_valid && i_edge_present;
            r_last  <= i_last_edge;
        end
        if (rdy2 && r_v1) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_v2;
    assign o_work  = r_work;

endmodule

FILE: hw/rtl/aedst_dist.sv
// Back end: shift-table lookup, shifted terms, final sum and output register.
// Depends on aedst_pkg for the tables and t_work.
module aedst_dist
    import aedst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_work             i_work,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DIST_W-1:0] o_edge_distance,
    output logic              o_distance_valid,
    output logic              o_final_edge
);

    logic              r_v1;
    logic [AXIS_W-1:0] r_major;
    logic [AXIS_W-1:0] r_sha;
    logic [AXIS_W-1:0] r_shb;
    logic              r_nz;
    logic              r_ok;
    logic              r_last;
    logic              r_v2;
    logic [DIST_W-1:0] r_dist;
    logic              r_dvalid;
    logic              r_final;
    logic [DIST_W-1:0] n_dist;
    logic              rdy1;
    logic              rdy2;
    logic [IDX_W-1:0]  idx;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        if (i_work.quo > DIV_STEPS'(RATIO_MAX)) begin
            idx = IDX_W'(RATIO_MAX);
        end else begin
            idx = IDX_W'(i_work.quo);
        end
    end

    always_comb begin
        if (!r_ok) begin
            n_dist = '0;
        end else if (r_nz) begin
            n_dist = DIST_W'(r_major) + DIST_W'(r_sha) + DIST_W'(r_shb);
        end else begin
            n_dist = DIST_W'(r_major);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_major <= i_work.major;
            r_sha   <= i_work.major >> SHIFT_A[idx];
            r_shb   <= i_work.major >> SHIFT_B[idx];
            r_nz    <= i_work.minor_nz;
            r_ok    <= i_work.ok;
            r_last  <= i_work.last;
        end
        if (rdy2 && r_v1) begin
            r_dist   <= n_dist;
            r_dvalid <= r_ok;
            r_final  <= r_last;
        end
    end

    assign o_valid          = r_v2;
    assign o_edge_distance  = r_dist;
    assign o_distance_valid = r_dvalid;
    assign o_final_edge     = r_final;

endmodule

FILE: hw/rtl/approx_euclid_distance_shift_table.sv
// Top level of the approximate Euclidean edge-length block.
// Depends on aedst_pkg, aedst_prep, aedst_div_cell and aedst_dist.
//
//   channel   valid / ready              payload
//   input     i_in_valid / o_in_ready    i_from_*, i_to_*, i_source_valid,
//                                        i_edge_present, i_last_edge
//   output    o_out_valid / i_out_ready  o_edge_distance, o_distance_valid,
//                                        o_final_edge
//
// One edge per cycle sustained while the output is not stalled; 2 front-end stages, one
// cell per ratio bit in the divider chain (5), 2 back-end stages.
// Every stage has its own valid bit and takes a beat when empty or when the
// next stage moves, so bubbles close up under an output stall.
// Synchronous active-low reset clears the valid bits only.
module approx_euclid_distance_shift_table
    import aedst_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [COORD_W-1:0] i_from_east,
    input  logic [COORD_W-1:0] i_from_north,
    input  logic [COORD_W-1:0] i_to_east,
    input  logic [COORD_W-1:0] i_to_north,
    input  logic               i_source_valid,
    input  logic               i_edge_present,
    input  logic               i_last_edge,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [DIST_W-1:0]  o_edge_distance,
    output logic               o_distance_valid,
    output logic               o_final_edge
);

    t_work w_work  [0:DIV_STEPS];
    logic  w_valid [0:DIV_STEPS];
    logic  w_ready [0:DIV_STEPS];

    aedst_prep u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_from_east    (i_from_east),
        .i_from_north   (i_from_north),
        .i_to_east      (i_to_east),
        .i_to_north     (i_to_north),
        .i_source_valid (i_source_valid),
        .i_edge_present (i_edge_present),
        .i_last_edge    (i_last_edge),
        .o_valid        (w_valid[0]),
        .i_ready        (w_ready[0]),
        .o_work         (w_work[0])
    );

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
        aedst_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_work  (w_work[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_work  (w_work[k+1])
        );
    end

    aedst_dist u_dist (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_valid[DIV_STEPS]),
        .o_ready          (w_ready[DIV_STEPS]),
        .i_work           (w_work[DIV_STEPS]),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_edge_distance  (o_edge_distance),
        .o_distance_valid (o_distance_valid),
        .o_final_edge     (o_final_edge)
    );

endmodule

FILE: hw/rtl/aedst_checker.sv
// Port-level checker for the approximate Euclidean distance block, bound to the top.
// Depends on aedst_pkg and the assertion macro header.
`include "approx_euclid_distance_shift_table_macros.svh"

module aedst_checker
    import aedst_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [DIST_W-1:0]  o_edge_distance,
    input logic               o_distance_valid,
    input logic               o_final_edge
);

    logic [DIST_W+1:0] out_beat;

    assign out_beat = {o_edge_distance, o_distance_valid, o_final_edge};

    // Hold a stalled output beat.
    `AEDST_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `AEDST_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(out_beat))
    // A skipped edge carries a zero distance.
    `AEDST_ASSERT_NOW(a_skip_zero, o_out_valid && !o_distance_valid, o_edge_distance == '0)
    // Empty output stage or a ready sink means the whole chain can advance.
    `AEDST_ASSERT_NOW(a_ready_free, !o_out_valid || i_out_ready, o_in_ready)

endmodule

bind approx_euclid_distance_shift_table aedst_checker u_aedst_checker (.*);

FILE: bench/approx_euclid_distance_shift_table_tb.sv
// Self-checking bench for the approximate Euclidean edge-length block.
// Predicts each edge length with its own shift tables and compares every output beat.
// Depends on aedst_pkg and approx_euclid_distance_shift_table.
`timescale 1ns / 1ps

module approx_euclid_distance_shift_table_tb;
    import aedst_pkg::*;

    localparam int RATIO_TOP   = 16;
    localparam int COORD_MAX_I = 1073741823;
    localparam int COORD_MIN_I = -1073741824;
    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 20;

    localparam int unsigned ALPHA_SHIFT [0:RATIO_TOP] =
        '{12, 9, 7, 6, 5, 5, 4, 4, 4, 3, 3, 3, 2, 2, 2, 2, 2};
    localparam int unsigned BETA_SHIFT [0:RATIO_TOP] =
        '{12, 9, 9, 8, 12, 6, 7, 5, 4, 5, 4, 4, 9, 5, 4, 3, 3};

    typedef struct {
        logic [COORD_W-1:0] from_e;
        logic [COORD_W-1:0] from_n;
        logic [COORD_W-1:0] to_e;
        logic [COORD_W-1:0] to_n;
        logic               src_ok;
        logic               link_ok;
        logic               last;
    } t_edge_in;

    typedef struct {
        logic [DIST_W-1:0] len;
        logic              len_ok;
        logic              last;
    } t_edge_len;

    class edge_length_board;
        t_edge_len          length_q[$];
        int                 mismatches;
        int                 checked;
        int                 skipped;
        int                 coincident;
        int                 single_axis;
        bit [RATIO_TOP:0]   ratios_hit;

        function t_edge_len predict_length(t_edge_in e);
            longint            d_e;
            longint            d_n;
            logic [DIST_W-1:0] major;
            logic [DIST_W-1:0] minor;
            logic [DIST_W-1:0] swap;
            longint unsigned   ratio;
            int                idx;
            t_edge_len         r;
            r.last   = e.last;
            r.len    = '0;
            r.len_ok = 1'b0;
            if (!(e.src_ok && e.link_ok)) begin
                skipped++;
                return r;
            end
            d_e = longint'($signed(e.from_e)) - longint'($signed(e.to_e));
            d_n = longint'($signed(e.from_n)) - longint'($signed(e.to_n));
            if (d_e < 0) d_e = -d_e;
            if (d_n < 0) d_n = -d_n;
            major = DIST_W'(d_e);
            minor = DIST_W'(d_n);
            if (major < minor) begin
                swap  = major;
                major = minor;
                minor = swap;
            end
            r.len_ok = 1'b1;
            r.len    = major;
            if (minor == 0) begin
                if (major == 0) coincident++;
                else single_axis++;
            end else begin
                ratio = (64'(minor) << 4) / 64'(major);
                if (ratio > RATIO_TOP) ratio = RATIO_TOP;
                idx = int'(ratio);
                ratios_hit[idx] = 1'b1;
                r.len = major + (major >> ALPHA_SHIFT[idx]) + (major >> BETA_SHIFT[idx]);
            end
            return r;
        endfunction

        function void note_link(t_edge_in e);
            length_q.push_back(predict_length(e));
        endfunction

        function void check_result(logic [DIST_W-1:0] got_len, logic got_ok, logic last);
            t_edge_len want;
            checked++;
            if (length_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: dist %0d valid %0b final %0b",
                             $time, got_len, got_ok, last);
                return;
            end
            want = length_q.pop_front();
            if (got_len !== want.len || got_ok !== want.len_ok || last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"[%0t] mismatch: dist exp %0d got %0d, valid exp %0b got %0b,",
                              " final exp %0b got %0b"},
                             $time, want.len, got_len, want.len_ok, got_ok, want.last, last);
            end
        endfunction

        function int pending();
            return length_q.size();
        endfunction
    endclass

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic [COORD_W-1:0] i_from_east    = '0;
    logic [COORD_W-1:0] i_from_north   = '0;
    logic [COORD_W-1:0] i_to_east      = '0;
    logic [COORD_W-1:0] i_to_north     = '0;
    logic               i_source_valid = 1'b0;
    logic               i_edge_present = 1'b0;
    logic               i_last_edge    = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic [DIST_W-1:0]  o_edge_distance;
    logic               o_distance_valid;
    logic               o_final_edge;

    edge_length_board board = new();

    int idle_pct       = 0;
    int stall_pct      = 0;
    int hold_req       = 0;
    int hold_left      = 0;
    int items_sent     = 0;
    int in_stall_beats = 0;

    approx_euclid_distance_shift_table u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_from_east      (i_from_east),
        .i_from_north     (i_from_north),
        .i_to_east        (i_to_east),
        .i_to_north       (i_to_north),
        .i_source_valid   (i_source_valid),
        .i_edge_present   (i_edge_present),
        .i_last_edge      (i_last_edge),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_edge_distance  (o_edge_distance),
        .o_distance_valid (o_distance_valid),
        .o_final_edge     (o_final_edge)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: a pending hold request overrides random stalls.
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Sample at the falling edge, where everything driven at the rising edge has settled.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                board.check_result(o_edge_distance, o_distance_valid, o_final_edge);
            if (i_in_valid && !o_in_ready)
                in_stall_beats++;
        end
    end

    initial begin
        #4_000_000;
        $display("[%0t] timeout with %0d results outstanding", $time, board.pending());
        $display("approx_euclid_distance_shift_table regression: fail");
        $finish;
    end

    function automatic t_edge_in make_link(input int fe, input int fn, input int te,
                                           input int tn, input bit sv, input bit ep,
                                           input bit last);
        t_edge_in e;
        e.from_e  = COORD_W'(fe);
        e.from_n  = COORD_W'(fn);
        e.to_e    = COORD_W'(te);
        e.to_n    = COORD_W'(tn);
        e.src_ok  = sv;
        e.link_ok = ep;
        e.last    = last;
        return e;
    endfunction

    function automatic t_edge_in random_link();
        t_edge_in           e;
        int                 kind;
        int                 span;
        int                 off_e;
        int                 off_n;
        logic [COORD_W-1:0] corner [6];
        kind     = $urandom_range(99);
        e.from_e = COORD_W'($urandom());
        e.from_n = COORD_W'($urandom());
        e.to_e   = COORD_W'($urandom());
        e.to_n   = COORD_W'($urandom());
        if (kind < 50) begin
            // Nearby nodes: short edges reach every ratio code.
            span  = 1 << $urandom_range(0, 20);
            off_e = int'($urandom_range(0, 2 * span)) - span;
            off_n = int'($urandom_range(0, 2 * span)) - span;
            case ($urandom_range(9))
                0: off_e = 0;
                1: off_n = 0;
                2: off_n = ($urandom_range(1)) ? off_e : -off_e;
                default: ;
            endcase
            e.to_e = e.from_e + COORD_W'(off_e);
            e.to_n = e.from_n + COORD_W'(off_n);
        end else if (kind >= 80) begin
            corner = '{COORD_W'(COORD_MAX_I), COORD_W'(COORD_MIN_I), '0, '1,
                       COORD_W'(1), COORD_W'($urandom())};
            e.from_e = corner[$urandom_range(5)];
            e.from_n = corner[$urandom_range(5)];
            e.to_e   = corner[$urandom_range(5)];
            e.to_n   = corner[$urandom_range(5)];
        end
        e.src_ok  = ($urandom_range(99) < 90);
        e.link_ok = ($urandom_range(99) < 88);
        e.last    = ($urandom_range(99) < 12);
        return e;
    endfunction

    // Offer one beat, after a random gap, and hold it until taken.
    task automatic send_link(input t_edge_in e);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_from_east    <= e.from_e;
        i_from_north   <= e.from_n;
        i_to_east      <= e.to_e;
        i_to_north     <= e.to_n;
        i_source_valid <= e.src_ok;
        i_edge_present <= e.link_ok;
        i_last_edge    <= e.last;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end
        board.note_link(e);
        items_sent++;
    endtask

    task automatic set_idling(input int idle, input int stall);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        idle_pct  = idle;
        stall_pct = stall;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    initial begin
        int k;
        int p;
        int phase_idle  [4];
        int phase_stall [4];
        phase_idle  = '{0, 51, 0, 23};
        phase_stall = '{0, 0, 51, 23};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_link(make_link(0, 0, 0, 0, 1, 1, 0));
        send_link(make_link(100, -200, -300, 400, 0, 1, 1));
        send_link(make_link(100, -200, -300, 400, 1, 0, 0));
        send_link(make_link(COORD_MAX_I, COORD_MIN_I, COORD_MIN_I, COORD_MAX_I, 0, 0, 1));
        send_link(make_link(COORD_MIN_I, 7, COORD_MAX_I, 7, 1, 1, 0));
        send_link(make_link(COORD_MIN_I, COORD_MIN_I, COORD_MAX_I, COORD_MAX_I, 1, 1, 1));
        send_link(make_link(COORD_MAX_I, COORD_MIN_I, COORD_MIN_I, COORD_MAX_I, 1, 1, 0));
        send_link(make_link(0, 5, 0, -7, 1, 1, 0));
        send_link(make_link(-1, -1, 2, 2, 1, 1, 0));
        send_link(make_link(0, 0, 1, 100, 1, 1, 0));
        // Sweep the minor axis against a major of 16 to walk the ratio codes.
        for (k = 1; k <= 15; k++)
            send_link(make_link(-8, k, 8, 0, 1, 1, k == 15));
        drain_results();

        for (p = 0; p < 4; p++) begin
            set_idling(phase_idle[p], phase_stall[p]);
            for (k = 0; k < 300; k++) begin
                if (p == 0 && k == 100) begin
                    // Block the output and keep pushing until the input stalls.
                    i_in_valid <= 1'b0;
                    @(negedge i_clk);
                    hold_req = HOLD_CYCLES;
                    @(posedge i_clk);
                end
                send_link(random_link());
            end
            drain_results();
        end

        set_idling(0, 0);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d edges, checked %0d results: %0d skipped, %0d coincident, %0d on one axis",
                 items_sent, board.checked, board.skipped, board.coincident, board.single_axis);
        $display("ratio codes hit %0d of %0d, input stalled %0d cycles, %0d mismatches",
                 $countones(board.ratios_hit), RATIO_TOP + 1, in_stall_beats, board.mismatches);
        if (board.pending() != 0)
            $display("%0d expected results never arrived", board.pending());
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("approx_euclid_distance_shift_table regression: pass");
        end else begin
            $display("approx_euclid_distance_shift_table regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/aedst_pkg.sv
hw/rtl/aedst_div_cell.sv
hw/rtl/aedst_prep.sv
hw/rtl/aedst_dist.sv
hw/rtl/approx_euclid_distance_shift_table.sv
hw/rtl/aedst_checker.sv
bench/approx_euclid_distance_shift_table_tb.sv
